/* rtl/srb_pkg.sv */
// shared types and constants of the sequence reorder buffer
package srb_pkg;

    // sizes (DEPTH must be a power of two that divides 2**SEQ_BITS)
    localparam int DEPTH       = 32;
    localparam int SEQ_BITS    = 16;
    localparam int HANDLE_BITS = 32;
    localparam int SLOT_BITS   = $clog2(DEPTH);

    // input beat
    typedef struct packed {
        logic [SEQ_BITS-1:0]    in_seq;
        logic [HANDLE_BITS-1:0] in_handle;
        logic                   in_twice;
    } t_in;

    // result beat
    typedef struct packed {
        logic [HANDLE_BITS-1:0] out_handle;
        logic [SEQ_BITS-1:0]    out_seq;
        logic                   out_twice;
        logic                   collision;
        logic                   last;
    } t_out;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_RELEASE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic insert;
        logic collide;
        logic release_slot;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic slot_busy;
        logic exp_valid;
        logic next_valid;
        logic out_free;
    } t_ctrl_sts;

endpackage

/* rtl/srb_ctrl.sv */
// controller state machine of the sequence reorder buffer
module srb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  srb_pkg::t_ctrl_sts i_sts,
    output srb_pkg::t_ctrl_cmd o_cmd
);

    srb_pkg::t_state r_state;
    srb_pkg::t_state n_state;
    logic            accept;

    // input side opens only when idle and the output register can take a beat
    assign o_in_stall = !(i_rst_n && (r_state == srb_pkg::ST_IDLE) && i_sts.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srb_pkg::ST_IDLE: begin
                if (accept && !i_sts.slot_busy) begin
                    n_state = srb_pkg::ST_RELEASE;
                end
            end
            srb_pkg::ST_RELEASE: begin
                if (!i_sts.exp_valid) begin
                    n_state = srb_pkg::ST_IDLE;
                end else if (i_sts.out_free && !i_sts.next_valid) begin
                    n_state = srb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srb_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            srb_pkg::ST_IDLE: begin
                o_cmd.insert  = accept && !i_sts.slot_busy;
                o_cmd.collide = accept && i_sts.slot_busy;
            end
            srb_pkg::ST_RELEASE: begin
                o_cmd.release_slot = i_sts.exp_valid && i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/srb_datapath.sv */
// slot store, expected counter and output register of the sequence reorder buffer
module srb_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srb_pkg::t_in       i_in,
    input  srb_pkg::t_ctrl_cmd i_cmd,
    output srb_pkg::t_ctrl_sts o_sts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srb_pkg::t_out      o_out
);

    logic [srb_pkg::DEPTH-1:0]       r_valid;
    logic [srb_pkg::HANDLE_BITS-1:0] r_handle [srb_pkg::DEPTH];
    logic                            r_twice  [srb_pkg::DEPTH];
    logic [srb_pkg::SEQ_BITS-1:0]    r_expected;
    logic                            r_out_valid;
    srb_pkg::t_out                   r_out;

    logic [srb_pkg::SLOT_BITS-1:0]   in_slot;
    logic [srb_pkg::SLOT_BITS-1:0]   exp_slot;
    logic [srb_pkg::SLOT_BITS-1:0]   nxt_slot;

    // slot indexes
    assign in_slot  = i_in.in_seq[srb_pkg::SLOT_BITS-1:0];
    assign exp_slot = r_expected[srb_pkg::SLOT_BITS-1:0];
    assign nxt_slot = exp_slot + srb_pkg::SLOT_BITS'(1);

    // status
    assign o_sts.slot_busy  = r_valid[in_slot];
    assign o_sts.exp_valid  = r_valid[exp_slot];
    assign o_sts.next_valid = r_valid[nxt_slot];
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    // slot valid bits and expected counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_expected <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_valid[in_slot] <= 1'b1;
            end
            if (i_cmd.release_slot) begin
                r_valid[exp_slot] <= 1'b0;
                r_expected        <= r_expected + srb_pkg::SEQ_BITS'(1);
            end
        end
    end

    // slot payload store
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_handle[in_slot] <= i_in.in_handle;
            r_twice[in_slot]  <= i_in.in_twice;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.collide || i_cmd.release_slot) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.collide) begin
            r_out.out_handle <= '0;
            r_out.out_seq    <= i_in.in_seq;
            r_out.out_twice  <= 1'b0;
            r_out.collision  <= 1'b1;
            r_out.last       <= 1'b1;
        end else if (i_cmd.release_slot) begin
            r_out.out_handle <= r_handle[exp_slot];
            r_out.out_seq    <= r_expected;
            r_out.out_twice  <= r_twice[exp_slot];
            r_out.collision  <= 1'b0;
            r_out.last       <= !r_valid[nxt_slot];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // an insert only lands in an empty slot
    a_insert_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> !r_valid[in_slot])
        else $error("insert into occupied slot");

    // a release only takes an occupied slot and never overwrites a waiting beat
    a_release_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.release_slot |-> (r_valid[exp_slot] && (!r_out_valid || !i_out_stall)))
        else $error("release from empty slot or into full output register");

    // counter advances by one on each release
    a_counter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.release_slot |=> (r_expected == $past(r_expected) + srb_pkg::SEQ_BITS'(1)))
        else $error("expected counter did not advance");

    // a collision beat is always the last beat of its item
    a_collision_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.collide |=> (r_out_valid && r_out.collision && r_out.last))
        else $error("collision beat malformed");

endmodule

/* rtl/sequence_reorder_buffer_top.sv */
// top level of the sequence reorder buffer
//
// Input channel i_in_valid / o_in_stall / i_in carries items with a sequence
// number, a payload handle and a write-twice flag. Each item is stored in
// slot (sequence mod 32). After the insert the block walks forward from the
// expected sequence counter and releases every occupied slot in order until
// it meets an empty one; each release is one beat on o_out_valid /
// i_out_stall / o_out, and the final beat of a run has last set.
// An item whose slot is already occupied is dropped and gives one collision
// beat (handle zero, offending sequence, last set).
// Timing: the accept cycle does the insert, then one entry is released per
// cycle while the receiver does not stall; an item that releases nothing
// still passes through the release state, and a collision stays in idle.
// The walk over the slot valid bits goes one slot at a time. Results come
// from an output register: a collision beat appears in the cycle after
// acceptance; a released beat passes the state and output registers.
// Reset (synchronous, active low) clears all slot valid bits and the counter
// at once; no clearing pass is needed. While the receiver stalls, the
// output beat holds and the release walk pauses; new items are refused
// until the current run has finished.
module sequence_reorder_buffer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  srb_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output srb_pkg::t_out o_out
);

    srb_pkg::t_ctrl_cmd cmd;
    srb_pkg::t_ctrl_sts sts;

    // controller
    srb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    srb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
